/* src/assert_macros.svh */
// assertion helpers for the pagerank edge engine
// expects aclk and aresetn in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PGR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pgr check failed");

// next-cycle implication
`define PGR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pgr check failed");

`endif

/* src/pgr_pkg.sv */
// shared types and constants for the pagerank edge engine
// no dependencies
package pgr_pkg;

    localparam int NODE_W    = 10;
    localparam int CNT_W     = 11;
    localparam int DAMP_W    = 16;
    localparam int RANK_W    = 32;
    localparam int SUM_W     = 64;
    localparam int DIV_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd2;

    localparam logic [CNT_W-1:0]  NODE_TOTAL_RST = 11'd1024;
    localparam logic [DAMP_W-1:0] DAMPING_RST    = 16'd55705;
    localparam logic [SUM_W-1:0]  TOLERANCE_RST  = 64'd1152922;

    typedef enum logic [1:0] {
        REQ_LOAD,
        REQ_EDGE,
        REQ_END,
        REQ_READ
    } req_t;

    typedef enum logic [1:0] {
        DIV_UNIFORM,
        DIV_TELEPORT,
        DIV_EDGE
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD_UNI,
        ST_LOAD_UNI_WAIT,
        ST_LOAD_TEL,
        ST_LOAD_TEL_WAIT,
        ST_LOAD_WR,
        ST_EDGE_CHK,
        ST_EDGE_DIV,
        ST_EDGE_WAIT,
        ST_EDGE_WR,
        ST_WALK,
        ST_DRAIN,
        ST_TEL,
        ST_TEL_WAIT,
        ST_FILL,
        ST_END_OUT,
        ST_READ_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        div_sel_t div_sel;
        logic     hold_uniform;
        logic     load_wr;
        logic     edge_wr;
        logic     walk_clear;
        logic     walk_issue;
        logic     fill_wr;
        logic     swap;
        logic     out_end;
        logic     out_read;
    } pgr_cmd_t;

    typedef struct packed {
        req_t kind;
        logic src_ok;
        logic dst_ok;
        logic deg_zero;
        logic div_busy;
        logic div_done;
        logic walk_last;
        logic pipe_busy;
    } pgr_sts_t;

endpackage

/* src/pagerank_edge_iteration.sv */
// pagerank edge engine, one item at a time; each division runs on the 64-step divider
// load: two divisions; edge: one division; read: no division
// end of iteration: a difference walk, one division, then a fill walk of
//   one node per cycle
// synchronous active-low reset clears control, config and bank select; tables
//   hold no reset value and need a load before use
`include "assert_macros.svh"

module pagerank_edge_iteration #(
    parameter int MAX_NODES      = 1024,
    parameter int RANK_FRAC_BITS = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pgr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [pgr_pkg::NODE_W-1:0]    s_source_node,
    input  logic [pgr_pkg::NODE_W-1:0]    s_dest_node,
    input  logic [pgr_pkg::CNT_W-1:0]     s_degree_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pgr_pkg::RANK_W-1:0]    m_rank_value,
    output logic [pgr_pkg::SUM_W-1:0]     m_diff_squared,
    output logic                          m_converged
);
    import pgr_pkg::*;

    pgr_cmd_t cmd;
    pgr_sts_t sts;

    pgr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pgr_dp #(
        .MAX_NODES      (MAX_NODES),
        .RANK_FRAC_BITS (RANK_FRAC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_req_type     (s_req_type),
        .s_source_node  (s_source_node),
        .s_dest_node    (s_dest_node),
        .s_degree_value (s_degree_value),
        .m_rank_value   (m_rank_value),
        .m_diff_squared (m_diff_squared),
        .m_converged    (m_converged),
        .cmd            (cmd),
        .sts            (sts)
    );

    `PGR_ASSERT_IMP(a_div_start_idle, cmd.div_start, !sts.div_busy)
    `PGR_ASSERT_IMP(a_accept_quiet, s_valid && s_ready, !sts.div_busy && !sts.pipe_busy)
    `PGR_ASSERT_IMP(a_edge_write_ok, cmd.edge_wr, !sts.deg_zero && sts.src_ok && sts.dst_ok)
    `PGR_ASSERT_NEXT(a_result_shown, cmd.out_end || cmd.out_read, m_valid)

endmodule

/* src/pgr_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module pgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/pgr_div.sv */
// restoring divider, one quotient bit per cycle, quotient saturated to rank width
// depends on pgr_pkg
module pgr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pgr_pkg::DIV_W-1:0]   dividend,
    input  logic [pgr_pkg::CNT_W-1:0]   divisor,
    output logic                        busy,
    output logic                        done,
    output logic [pgr_pkg::RANK_W-1:0]  quotient
);
    import pgr_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    always_comb begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? CNT_W'(trial - {1'b0, dsr_reg}) : CNT_W'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == STEP_W'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + STEP_W'(1);
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = (|quo_reg[DIV_W-1:RANK_W]) ? '1 : quo_reg[RANK_W-1:0];

endmodule

/* src/pgr_ctrl.sv */
// sequencing state machine for the pagerank edge engine
// depends on pgr_pkg
module pgr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pgr_pkg::pgr_sts_t sts,
    output pgr_pkg::pgr_cmd_t cmd
);
    import pgr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DIV_UNIFORM;
        s_ready     = 1'b0;
        out_free    = !out_valid_reg || m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.kind)
                    REQ_LOAD: state_next = sts.src_ok ? ST_LOAD_UNI : ST_IDLE;
                    REQ_EDGE: state_next = (sts.src_ok && sts.dst_ok) ? ST_EDGE_CHK : ST_IDLE;
                    REQ_END: begin
                        cmd.walk_clear = 1'b1;
                        state_next     = ST_WALK;
                    end
                    REQ_READ: state_next = ST_READ_OUT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_LOAD_UNI: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_UNIFORM;
                state_next    = ST_LOAD_UNI_WAIT;
            end
            ST_LOAD_UNI_WAIT: begin
                if (sts.div_done) begin
                    cmd.hold_uniform = 1'b1;
                    state_next       = ST_LOAD_TEL;
                end
            end
            ST_LOAD_TEL: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TELEPORT;
                state_next    = ST_LOAD_TEL_WAIT;
            end
            ST_LOAD_TEL_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_LOAD_WR;
                end
            end
            ST_LOAD_WR: begin
                cmd.load_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            // read data and product are settling here
            ST_EDGE_CHK: begin
                state_next = sts.deg_zero ? ST_IDLE : ST_EDGE_DIV;
            end
            ST_EDGE_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_EDGE;
                state_next    = ST_EDGE_WAIT;
            end
            ST_EDGE_WAIT: begin
                cmd.div_sel = DIV_EDGE;
                if (sts.div_done) begin
                    state_next = ST_EDGE_WR;
                end
            end
            ST_EDGE_WR: begin
                cmd.edge_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_WALK: begin
                cmd.walk_issue = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_TEL;
                end
            end
            ST_TEL: begin
                cmd.div_start  = 1'b1;
                cmd.div_sel    = DIV_TELEPORT;
                cmd.walk_clear = 1'b1;
                state_next     = ST_TEL_WAIT;
            end
            ST_TEL_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_wr = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_END_OUT;
                end
            end
            ST_END_OUT: begin
                if (out_free) begin
                    cmd.out_end = 1'b1;
                    cmd.swap    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_READ_OUT: begin
                if (out_free) begin
                    cmd.out_read = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_end || cmd.out_read) begin
            out_valid_next = 1'b1;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

/* src/pgr_dp.sv */
// datapath: config registers, rank and degree memories, divider, walk pipeline
// depends on pgr_pkg, pgr_ram, pgr_div
module pgr_dp #(
    parameter int MAX_NODES      = 1024,
    parameter int RANK_FRAC_BITS = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pgr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [1:0]                    s_req_type,
    input  logic [pgr_pkg::NODE_W-1:0]    s_source_node,
    input  logic [pgr_pkg::NODE_W-1:0]    s_dest_node,
    input  logic [pgr_pkg::CNT_W-1:0]     s_degree_value,
    output logic [pgr_pkg::RANK_W-1:0]    m_rank_value,
    output logic [pgr_pkg::SUM_W-1:0]     m_diff_squared,
    output logic                          m_converged,
    input  pgr_pkg::pgr_cmd_t             cmd,
    output pgr_pkg::pgr_sts_t             sts
);
    import pgr_pkg::*;

    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int PROD_W = DAMP_W + RANK_W;

    logic [CNT_W-1:0]  node_total_reg;
    logic [DAMP_W-1:0] damping_reg;
    logic [SUM_W-1:0]  tolerance_reg;

    req_t              kind_reg;
    logic [NODE_W-1:0] src_reg;
    logic [NODE_W-1:0] dst_reg;
    logic [CNT_W-1:0]  deg_reg;

    logic [CNT_W-1:0]  n_act;
    logic [31:0]       src_wide, dst_wide;
    logic [ADDR_W-1:0] src_addr, dst_addr;
    logic              src_ok, dst_ok;

    logic [ADDR_W-1:0] k_reg;
    logic              walk_last;
    logic              sel_reg;

    logic [ADDR_W-1:0] old_addr, new_addr, old_wr_addr, new_wr_addr;
    logic [RANK_W-1:0] old_wr_data, new_wr_data;
    logic              old_we, new_we;
    logic              we0, we1;
    logic [ADDR_W-1:0] wa0, wa1, ra0, ra1;
    logic [RANK_W-1:0] wd0, wd1, rd0, rd1;
    logic [RANK_W-1:0] old_rdata, new_rdata;
    logic [CNT_W-1:0]  deg_rdata;

    logic [PROD_W-1:0] prod_reg;
    logic [RANK_W-1:0] uni_reg;
    logic [16:0]       keep;
    logic [DIV_W-1:0]  div_dvd;
    logic [CNT_W-1:0]  div_dsr;
    logic              div_busy, div_done;
    logic [RANK_W-1:0] quot;
    logic [RANK_W:0]   edge_sum;

    logic              v1_reg, v2_reg, v3_reg;
    logic [RANK_W-1:0] diff_reg;
    logic [SUM_W-1:0]  sq_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W:0]    sum_wide;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_total_reg <= NODE_TOTAL_RST;
            damping_reg    <= DAMPING_RST;
            tolerance_reg  <= TOLERANCE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NODE_TOTAL: node_total_reg <= cfg_wdata[CNT_W-1:0];
                CFG_DAMPING:    damping_reg    <= cfg_wdata[DAMP_W-1:0];
                CFG_TOLERANCE:  tolerance_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= req_t'(s_req_type);
            src_reg  <= s_source_node;
            dst_reg  <= s_dest_node;
            deg_reg  <= s_degree_value;
        end
    end

    // zero node count acts as one, and the count is clipped to the table depth
    always_comb begin
        if (node_total_reg == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(node_total_reg) > 32'(MAX_NODES)) begin
            n_act = CNT_W'(MAX_NODES);
        end else begin
            n_act = node_total_reg;
        end
        src_wide  = 32'(src_reg);
        dst_wide  = 32'(dst_reg);
        src_addr  = src_wide[ADDR_W-1:0];
        dst_addr  = dst_wide[ADDR_W-1:0];
        src_ok    = src_wide < 32'(n_act);
        dst_ok    = dst_wide < 32'(n_act);
        walk_last = 32'(k_reg) == 32'(n_act) - 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_clear) begin
            k_reg <= '0;
        end else if (cmd.walk_issue || cmd.fill_wr) begin
            k_reg <= k_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else if (cmd.swap) begin
            sel_reg <= ~sel_reg;
        end
    end

    // map old and new roles onto the two physical banks
    always_comb begin
        old_addr    = (kind_reg == REQ_END) ? k_reg : src_addr;
        new_addr    = (kind_reg == REQ_END) ? k_reg : dst_addr;
        old_wr_addr = (kind_reg == REQ_END) ? k_reg : src_addr;
        new_wr_addr = (kind_reg == REQ_EDGE) ? dst_addr : src_addr;
        edge_sum    = {1'b0, new_rdata} + {1'b0, quot};
        old_wr_data = cmd.fill_wr ? quot : uni_reg;
        new_wr_data = cmd.edge_wr ? (edge_sum[RANK_W] ? '1 : edge_sum[RANK_W-1:0]) : quot;
        old_we      = cmd.load_wr || cmd.fill_wr;
        new_we      = cmd.load_wr || cmd.edge_wr;
        we0         = sel_reg ? new_we : old_we;
        we1         = sel_reg ? old_we : new_we;
        wa0         = sel_reg ? new_wr_addr : old_wr_addr;
        wa1         = sel_reg ? old_wr_addr : new_wr_addr;
        wd0         = sel_reg ? new_wr_data : old_wr_data;
        wd1         = sel_reg ? old_wr_data : new_wr_data;
        ra0         = sel_reg ? new_addr : old_addr;
        ra1         = sel_reg ? old_addr : new_addr;
        old_rdata   = sel_reg ? rd1 : rd0;
        new_rdata   = sel_reg ? rd0 : rd1;
    end

    pgr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_bank0 (
        .aclk    (aclk),
        .wr_en   (we0),
        .wr_addr (wa0),
        .wr_data (wd0),
        .rd_addr (ra0),
        .rd_data (rd0)
    );

    pgr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_bank1 (
        .aclk    (aclk),
        .wr_en   (we1),
        .wr_addr (wa1),
        .wr_data (wd1),
        .rd_addr (ra1),
        .rd_data (rd1)
    );

    pgr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_degree (
        .aclk    (aclk),
        .wr_en   (cmd.load_wr),
        .wr_addr (src_addr),
        .wr_data (deg_reg),
        .rd_addr (src_addr),
        .rd_data (deg_rdata)
    );

    // d * old[src], the /65536 is folded into the dividend
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(damping_reg) * PROD_W'(old_rdata);
        if (cmd.hold_uniform) begin
            uni_reg <= quot;
        end
    end

    always_comb begin
        keep = 17'h10000 - {1'b0, damping_reg};
        case (cmd.div_sel)
            DIV_UNIFORM:  div_dvd = DIV_W'(1) << RANK_FRAC_BITS;
            DIV_TELEPORT: div_dvd = DIV_W'(keep) << (RANK_FRAC_BITS - 16);
            DIV_EDGE:     div_dvd = DIV_W'(prod_reg[PROD_W-1:16]);
            default:      div_dvd = '0;
        endcase
        div_dsr = (cmd.div_sel == DIV_EDGE) ? deg_rdata : n_act;
    end

    pgr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quot)
    );

    // walk pipeline: read, abs difference, square, saturating accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.walk_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign sum_wide = {1'b0, sum_reg} + {1'b0, sq_reg};

    always_ff @(posedge aclk) begin
        diff_reg <= (new_rdata > old_rdata) ? new_rdata - old_rdata : old_rdata - new_rdata;
        sq_reg   <= SUM_W'(diff_reg) * SUM_W'(diff_reg);
        if (cmd.capture) begin
            sum_reg <= '0;
        end else if (v3_reg) begin
            sum_reg <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_end) begin
            m_rank_value   <= '0;
            m_diff_squared <= sum_reg;
            m_converged    <= sum_reg <= tolerance_reg;
        end else if (cmd.out_read) begin
            m_rank_value   <= src_ok ? old_rdata : '0;
            m_diff_squared <= '0;
            m_converged    <= 1'b0;
        end
    end

    always_comb begin
        sts.kind      = kind_reg;
        sts.src_ok    = src_ok;
        sts.dst_ok    = dst_ok;
        sts.deg_zero  = deg_rdata == '0;
        sts.div_busy  = div_busy;
        sts.div_done  = div_done;
        sts.walk_last = walk_last;
        sts.pipe_busy = v1_reg || v2_reg || v3_reg;
    end

endmodule
